// ===== hw/rtl/gcqs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gcqs_pkg;

    localparam int QUAT_W     = 16;
    localparam int SCALE_W    = 24;
    localparam int COV_W      = 48;
    localparam int LANES      = 9;
    localparam int ENTRIES    = 6;
    localparam int AXES       = 3;
    localparam int DIV_STAGES = 32;
    localparam int N_W        = 33;
    localparam int NUM_W      = 33;
    localparam int REM_W      = 33;
    localparam int QUO_W      = 32;
    localparam int SPROD_W    = 2 * SCALE_W;
    localparam int SHALF_W    = SCALE_W;
    localparam int RMAG_W     = 32;
    localparam int M_W        = 50;
    localparam int MHALF_W    = M_W / 2;
    localparam int TERM_W     = 2 * M_W;
    localparam int ACC_W      = TERM_W + 3;
    localparam int FRAC_SHIFT = 30;
    localparam int ROUND_SHIFT = 32;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_SCALE_MOD = 1'b0;
    localparam logic [SCALE_W-1:0] SCALE_MOD_RESET = 24'd65536;

    // rows of M that feed each upper-triangle entry
    localparam int ROW_A [ENTRIES] = '{0, 0, 0, 1, 1, 2};
    localparam int ROW_B [ENTRIES] = '{0, 1, 2, 1, 2, 2};

    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
        logic [SCALE_W-1:0]       scale_x;
        logic [SCALE_W-1:0]       scale_y;
        logic [SCALE_W-1:0]       scale_z;
    } in_t;

    typedef struct packed {
        logic signed [COV_W-1:0] cov_xx;
        logic signed [COV_W-1:0] cov_xy;
        logic signed [COV_W-1:0] cov_xz;
        logic signed [COV_W-1:0] cov_yy;
        logic signed [COV_W-1:0] cov_yz;
        logic signed [COV_W-1:0] cov_zz;
        logic                    zero_quaternion;
        logic                    saturated;
    } out_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } div_lane_t;

    typedef div_lane_t [LANES-1:0] lane_vec_t;

    typedef struct packed {
        logic [N_W-1:0]                 n;
        logic [LANES-1:0]               neg;
        logic [AXES-1:0][SPROD_W-1:0]   scale;
        logic                           zero;
    } div_side_t;

endpackage
`default_nettype wire

// ===== hw/rtl/gaussian_covariance_from_quat_scale_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Builds the 3D covariance of one Gaussian per transaction from its quaternion
// and axis scales: the quaternion is normalized inside the rotation divide, the
// scales are multiplied by scale_modifier, and the six upper-triangle entries
// of R*S*S^T*R^T come out in Q16.32, saturated, with flags for a zero
// quaternion and for clipping. One item is accepted every cycle unless item_stall
// is high, and the bulk of the pipeline is the 32-stage restoring divider that
// produces one quotient bit per stage for the nine rotation entries. A stalled
// result is held in an output register with one skid entry behind it, so the
// input stalls only once both are full.
module gaussian_covariance_from_quat_scale_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             item_valid,
    output logic                                  item_stall,
    input  wire gcqs_pkg::in_t                    item,
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output gcqs_pkg::out_t                        result,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [gcqs_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [gcqs_pkg::DATA_W-1:0]      pwdata,
    output logic [gcqs_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready
);
    import gcqs_pkg::*;

    logic [SCALE_W-1:0] scale_mod_reg;
    logic               reg_hit;

    logic      en;
    logic      front_valid, div_valid, back_valid;
    lane_vec_t front_lanes, div_lanes;
    div_side_t front_side, div_side;
    out_t      back_result;

    logic out_v_reg, out_v_next;
    logic skid_v_reg, skid_v_next;
    out_t result_reg, result_next;
    out_t skid_reg, skid_next;

    assign reg_hit = (paddr[ADDR_W-1:2] == REG_SCALE_MOD);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? DATA_W'(scale_mod_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_mod_reg <= SCALE_MOD_RESET;
        end
        else if (psel && penable && pwrite && reg_hit)
        begin
            scale_mod_reg <= pwdata[SCALE_W-1:0];
        end
    end

    assign en         = !skid_v_reg;
    assign item_stall = skid_v_reg;

    gcqs_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (item_valid),
        .item           (item),
        .scale_modifier (scale_mod_reg),
        .valid          (front_valid),
        .lanes          (front_lanes),
        .side           (front_side)
    );

    gcqs_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (front_valid),
        .lanes_in  (front_lanes),
        .side_in   (front_side),
        .valid_out (div_valid),
        .lanes_out (div_lanes),
        .side_out  (div_side)
    );

    gcqs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .valid_in (div_valid),
        .lanes_in (div_lanes),
        .side_in  (div_side),
        .valid    (back_valid),
        .result   (back_result)
    );

    // output register plus one skid entry
    always_comb
    begin
        out_v_next  = out_v_reg;
        result_next = result_reg;
        skid_v_next = skid_v_reg;
        skid_next   = skid_reg;
        if (!out_v_reg || !result_stall)
        begin
            if (skid_v_reg)
            begin
                out_v_next  = 1'b1;
                result_next = skid_reg;
                skid_v_next = 1'b0;
            end
            else
            begin
                out_v_next  = back_valid;
                result_next = back_result;
            end
        end
        else if (back_valid && !skid_v_reg)
        begin
            skid_v_next = 1'b1;
            skid_next   = back_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        skid_reg   <= skid_next;
    end

    assign result_valid = out_v_reg;
    assign result       = result_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/gcqs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gcqs_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            en,
    input  wire logic                            in_valid,
    input  wire gcqs_pkg::in_t                   item,
    input  wire logic [gcqs_pkg::SCALE_W-1:0]    scale_modifier,
    output logic                                 valid,
    output gcqs_pkg::lane_vec_t                  lanes,
    output gcqs_pkg::div_side_t                  side
);
    import gcqs_pkg::*;

    localparam int P_W    = 2 * QUAT_W;
    localparam int NUMS_W = NUM_W + 2;
    localparam int DVD_W  = NUM_W + FRAC_SHIFT;

    // stage 1: component products and scale products
    logic signed [P_W-1:0] ww_reg, xx_reg, yy_reg, zz_reg, xy_reg;
    logic signed [P_W-1:0] wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    logic [SPROD_W-1:0] scale1_reg [AXES];
    logic v1_reg;

    // stage 2: norm and numerator magnitudes
    logic [N_W-1:0]   n2_reg;
    logic [NUM_W-1:0] mag2_reg [LANES];
    logic [LANES-1:0] neg2_reg;
    logic [SPROD_W-1:0] scale2_reg [AXES];
    logic zero2_reg;
    logic v2_reg;

    // stage 3: divider setup
    lane_vec_t lanes3_reg;
    div_side_t side3_reg;
    logic v3_reg;

    logic signed [NUMS_W-1:0] num [LANES];
    logic signed [NUMS_W-1:0] abs_v [LANES];
    logic [N_W-1:0] n_next;
    logic [DVD_W-1:0] dividend [LANES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ww_reg <= item.quat_w * item.quat_w;
            xx_reg <= item.quat_x * item.quat_x;
            yy_reg <= item.quat_y * item.quat_y;
            zz_reg <= item.quat_z * item.quat_z;
            xy_reg <= item.quat_x * item.quat_y;
            wz_reg <= item.quat_w * item.quat_z;
            xz_reg <= item.quat_x * item.quat_z;
            wy_reg <= item.quat_w * item.quat_y;
            yz_reg <= item.quat_y * item.quat_z;
            wx_reg <= item.quat_w * item.quat_x;
            scale1_reg[0] <= SPROD_W'(item.scale_x) * SPROD_W'(scale_modifier);
            scale1_reg[1] <= SPROD_W'(item.scale_y) * SPROD_W'(scale_modifier);
            scale1_reg[2] <= SPROD_W'(item.scale_z) * SPROD_W'(scale_modifier);
        end
    end

    always_comb
    begin
        n_next = N_W'(ww_reg) + N_W'(xx_reg) + N_W'(yy_reg) + N_W'(zz_reg);
        num[0] = (NUMS_W'(yy_reg) + NUMS_W'(zz_reg)) <<< 1;
        num[1] = (NUMS_W'(xy_reg) - NUMS_W'(wz_reg)) <<< 1;
        num[2] = (NUMS_W'(xz_reg) + NUMS_W'(wy_reg)) <<< 1;
        num[3] = (NUMS_W'(xy_reg) + NUMS_W'(wz_reg)) <<< 1;
        num[4] = (NUMS_W'(xx_reg) + NUMS_W'(zz_reg)) <<< 1;
        num[5] = (NUMS_W'(yz_reg) - NUMS_W'(wx_reg)) <<< 1;
        num[6] = (NUMS_W'(xz_reg) - NUMS_W'(wy_reg)) <<< 1;
        num[7] = (NUMS_W'(yz_reg) + NUMS_W'(wx_reg)) <<< 1;
        num[8] = (NUMS_W'(xx_reg) + NUMS_W'(yy_reg)) <<< 1;
        for (int l = 0; l < LANES; l++)
        begin
            abs_v[l] = num[l][NUMS_W-1] ? -num[l] : num[l];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n2_reg    <= n_next;
            zero2_reg <= (n_next == '0);
            for (int l = 0; l < LANES; l++)
            begin
                mag2_reg[l] <= abs_v[l][NUM_W-1:0];
                neg2_reg[l] <= num[l][NUMS_W-1];
            end
            for (int k = 0; k < AXES; k++)
            begin
                scale2_reg[k] <= scale1_reg[k];
            end
        end
    end

    // dividend = |2A| * 2^30 + floor(n/2); upper part seeds the remainder
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            dividend[l] = {mag2_reg[l], {FRAC_SHIFT{1'b0}}} + DVD_W'(n2_reg[N_W-1:1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                lanes3_reg[l].rem <= REM_W'(dividend[l][DVD_W-1:QUO_W]);
                lanes3_reg[l].quo <= dividend[l][QUO_W-1:0];
            end
            side3_reg.n    <= n2_reg;
            side3_reg.neg  <= neg2_reg;
            side3_reg.zero <= zero2_reg;
            for (int k = 0; k < AXES; k++)
            begin
                side3_reg.scale[k] <= scale2_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign valid = v3_reg;
    assign lanes = lanes3_reg;
    assign side  = side3_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/gcqs_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gcqs_divider (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 valid_in,
    input  wire gcqs_pkg::lane_vec_t  lanes_in,
    input  wire gcqs_pkg::div_side_t  side_in,
    output logic                      valid_out,
    output gcqs_pkg::lane_vec_t       lanes_out,
    output gcqs_pkg::div_side_t       side_out
);
    import gcqs_pkg::*;

    logic      valid_reg [DIV_STAGES];
    lane_vec_t lane_reg  [DIV_STAGES];
    div_side_t side_reg  [DIV_STAGES];

    // restoring division, one quotient bit per stage for all nine lanes
    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : gen_stage
        lane_vec_t src;
        div_side_t src_side;
        logic      src_valid;
        lane_vec_t lane_next;

        if (j == 0)
        begin : gen_first
            assign src       = lanes_in;
            assign src_side  = side_in;
            assign src_valid = valid_in;
        end
        else
        begin : gen_rest
            assign src       = lane_reg[j-1];
            assign src_side  = side_reg[j-1];
            assign src_valid = valid_reg[j-1];
        end

        always_comb
        begin
            logic [REM_W:0]   trial;
            logic [REM_W+1:0] diff;
            logic             ge;
            for (int l = 0; l < LANES; l++)
            begin
                trial = {src[l].rem, src[l].quo[QUO_W-1]};
                diff  = {1'b0, trial} - {2'b00, src_side.n};
                ge    = !diff[REM_W+1];
                lane_next[l].rem = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
                lane_next[l].quo = {src[l].quo[QUO_W-2:0], ge};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lane_reg[j] <= lane_next;
                side_reg[j] <= src_side;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= src_valid;
            end
        end
    end

    assign valid_out = valid_reg[DIV_STAGES-1];
    assign lanes_out = lane_reg[DIV_STAGES-1];
    assign side_out  = side_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== hw/rtl/gcqs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gcqs_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 valid_in,
    input  wire gcqs_pkg::lane_vec_t  lanes_in,
    input  wire gcqs_pkg::div_side_t  side_in,
    output logic                      valid,
    output gcqs_pkg::out_t            result
);
    import gcqs_pkg::*;

    localparam int T_W    = QUO_W + 2;
    localparam int PP_W   = RMAG_W + SHALF_W;
    localparam int PROD_W = RMAG_W + SPROD_W;
    localparam int MPP_W  = 2 * MHALF_W;
    localparam int TERMS  = ENTRIES * AXES;
    localparam int R_W    = ACC_W - ROUND_SHIFT;
    localparam logic signed [T_W-1:0] ONE_Q30 =
        {{(T_W-1-FRAC_SHIFT){1'b0}}, 1'b1, {FRAC_SHIFT{1'b0}}};
    localparam logic [PROD_W-1:0] M_ROUND =
        {{(PROD_W-FRAC_SHIFT){1'b0}}, 1'b1, {(FRAC_SHIFT-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ACC_ROUND =
        {{(ACC_W-ROUND_SHIFT){1'b0}}, 1'b1, {(ROUND_SHIFT-1){1'b0}}};
    localparam logic [COV_W-1:0] SAT_POS = {1'b0, {(COV_W-1){1'b1}}};
    localparam logic [COV_W-1:0] SAT_NEG = {1'b1, {(COV_W-1){1'b0}}};

    // b1: rotation entries as sign and magnitude
    logic [RMAG_W-1:0]  rmag1_reg [LANES];
    logic [LANES-1:0]   rneg1_reg;
    logic [SPROD_W-1:0] scale1_reg [AXES];
    logic zero1_reg, v1_reg;
    // b2: partial products of |R| * s
    logic [PP_W-1:0]    pl2_reg [LANES];
    logic [PP_W-1:0]    ph2_reg [LANES];
    logic [LANES-1:0]   neg2_reg;
    logic zero2_reg, v2_reg;
    // b3: entries of M
    logic [M_W-1:0]     mmag3_reg [LANES];
    logic [LANES-1:0]   neg3_reg;
    logic zero3_reg, v3_reg;
    // b4: partial products of the covariance terms
    logic [MPP_W-1:0]   ll4_reg [TERMS];
    logic [MPP_W-1:0]   lh4_reg [TERMS];
    logic [MPP_W-1:0]   hl4_reg [TERMS];
    logic [MPP_W-1:0]   hh4_reg [TERMS];
    logic [TERMS-1:0]   tneg4_reg;
    logic zero4_reg, v4_reg;
    // b5: term magnitudes
    logic [TERM_W-1:0]  tmag5_reg [TERMS];
    logic [TERMS-1:0]   tneg5_reg;
    logic zero5_reg, v5_reg;
    // b6: signed terms
    logic signed [TERM_W:0] term6_reg [TERMS];
    logic zero6_reg, v6_reg;
    // b7: rounded sums
    logic signed [ACC_W-1:0] acc7_reg [ENTRIES];
    logic zero7_reg, v7_reg;
    // b8: saturated result
    out_t result8_reg;
    logic v8_reg;

    logic [RMAG_W-1:0]  rmag_next [LANES];
    logic [LANES-1:0]   rneg_next;
    logic [PROD_W-1:0]  prod [LANES];
    logic [COV_W-1:0]   cov [ENTRIES];
    logic [ENTRIES-1:0] clip;

    always_comb
    begin
        logic signed [T_W-1:0] t;
        logic signed [T_W-1:0] t_abs;
        for (int l = 0; l < LANES; l++)
        begin
            t     = ONE_Q30 - $signed({2'b00, lanes_in[l].quo});
            t_abs = t[T_W-1] ? -t : t;
            if (l % (AXES + 1) == 0)
            begin
                rneg_next[l] = t[T_W-1];
                rmag_next[l] = t_abs[RMAG_W-1:0];
            end
            else
            begin
                rneg_next[l] = side_in.neg[l];
                rmag_next[l] = lanes_in[l].quo;
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            prod[l] = {ph2_reg[l], {SHALF_W{1'b0}}} + PROD_W'(pl2_reg[l]) + M_ROUND;
        end
    end

    always_comb
    begin
        logic signed [R_W-1:0] r;
        logic [R_W-COV_W:0]    top;
        for (int e = 0; e < ENTRIES; e++)
        begin
            r   = acc7_reg[e][ACC_W-1:ROUND_SHIFT];
            top = r[R_W-1:COV_W-1];
            if ((&top) || !(|top))
            begin
                cov[e]  = r[COV_W-1:0];
                clip[e] = 1'b0;
            end
            else
            begin
                cov[e]  = r[R_W-1] ? SAT_NEG : SAT_POS;
                clip[e] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rmag1_reg[l] <= rmag_next[l];
                pl2_reg[l]   <= PP_W'(rmag1_reg[l])
                              * PP_W'(scale1_reg[l % AXES][SHALF_W-1:0]);
                ph2_reg[l]   <= PP_W'(rmag1_reg[l])
                              * PP_W'(scale1_reg[l % AXES][SPROD_W-1:SHALF_W]);
                mmag3_reg[l] <= prod[l][FRAC_SHIFT+M_W-1:FRAC_SHIFT];
            end
            rneg1_reg <= rneg_next;
            neg2_reg  <= rneg1_reg;
            neg3_reg  <= neg2_reg;
            for (int k = 0; k < AXES; k++)
            begin
                scale1_reg[k] <= side_in.scale[k];
            end

            for (int e = 0; e < ENTRIES; e++)
            begin
                for (int k = 0; k < AXES; k++)
                begin
                    ll4_reg[e*AXES+k] <=
                        MPP_W'(mmag3_reg[ROW_A[e]*AXES+k][MHALF_W-1:0])
                      * MPP_W'(mmag3_reg[ROW_B[e]*AXES+k][MHALF_W-1:0]);
                    lh4_reg[e*AXES+k] <=
                        MPP_W'(mmag3_reg[ROW_A[e]*AXES+k][MHALF_W-1:0])
                      * MPP_W'(mmag3_reg[ROW_B[e]*AXES+k][M_W-1:MHALF_W]);
                    hl4_reg[e*AXES+k] <=
                        MPP_W'(mmag3_reg[ROW_A[e]*AXES+k][M_W-1:MHALF_W])
                      * MPP_W'(mmag3_reg[ROW_B[e]*AXES+k][MHALF_W-1:0]);
                    hh4_reg[e*AXES+k] <=
                        MPP_W'(mmag3_reg[ROW_A[e]*AXES+k][M_W-1:MHALF_W])
                      * MPP_W'(mmag3_reg[ROW_B[e]*AXES+k][M_W-1:MHALF_W]);
                    tneg4_reg[e*AXES+k] <= neg3_reg[ROW_A[e]*AXES+k]
                                         ^ neg3_reg[ROW_B[e]*AXES+k];
                end
            end

            for (int t = 0; t < TERMS; t++)
            begin
                tmag5_reg[t] <= {hh4_reg[t], {MPP_W{1'b0}}}
                              + (TERM_W'(lh4_reg[t]) << MHALF_W)
                              + (TERM_W'(hl4_reg[t]) << MHALF_W)
                              + TERM_W'(ll4_reg[t]);
                term6_reg[t] <= tneg5_reg[t] ? -$signed({1'b0, tmag5_reg[t]})
                                             : $signed({1'b0, tmag5_reg[t]});
            end
            tneg5_reg <= tneg4_reg;

            for (int e = 0; e < ENTRIES; e++)
            begin
                acc7_reg[e] <= ACC_W'(term6_reg[e*AXES])
                             + ACC_W'(term6_reg[e*AXES+1])
                             + ACC_W'(term6_reg[e*AXES+2]) + ACC_ROUND;
            end

            zero1_reg <= side_in.zero;
            zero2_reg <= zero1_reg;
            zero3_reg <= zero2_reg;
            zero4_reg <= zero3_reg;
            zero5_reg <= zero4_reg;
            zero6_reg <= zero5_reg;
            zero7_reg <= zero6_reg;

            // zero quaternion forces a clean all-zero covariance
            result8_reg.cov_xx <= zero7_reg ? '0 : cov[0];
            result8_reg.cov_xy <= zero7_reg ? '0 : cov[1];
            result8_reg.cov_xz <= zero7_reg ? '0 : cov[2];
            result8_reg.cov_yy <= zero7_reg ? '0 : cov[3];
            result8_reg.cov_yz <= zero7_reg ? '0 : cov[4];
            result8_reg.cov_zz <= zero7_reg ? '0 : cov[5];
            result8_reg.zero_quaternion <= zero7_reg;
            result8_reg.saturated <= !zero7_reg && (|clip);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    assign valid  = v8_reg;
    assign result = result8_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/gcqs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gcqs_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             item_valid,
    input wire logic                             item_stall,
    input wire gcqs_pkg::in_t                    item,
    input wire logic                             result_valid,
    input wire logic                             result_stall,
    input wire gcqs_pkg::out_t                   result,
    input wire logic                             psel,
    input wire logic                             penable,
    input wire logic                             pwrite,
    input wire logic [gcqs_pkg::ADDR_W-1:0]      paddr,
    input wire logic [gcqs_pkg::DATA_W-1:0]      pwdata,
    input wire logic [gcqs_pkg::DATA_W-1:0]      prdata,
    input wire logic                             pready
);
    import gcqs_pkg::*;

    logic unused_ok;
    assign unused_ok = item_valid ^ (^item) ^ psel ^ penable ^ pwrite ^ (^paddr)
                     ^ (^pwdata) ^ (^prdata) ^ pready;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result changed while stalled");

    // the input only backs up once a result is already waiting
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("input stalled with no pending result");

    a_zero_quat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.zero_quaternion |->
            result.cov_xx == '0 && result.cov_xy == '0 && result.cov_xz == '0 &&
            result.cov_yy == '0 && result.cov_yz == '0 && result.cov_zz == '0 &&
            !result.saturated)
        else $error("zero quaternion with nonzero covariance");

    // diagonal entries are sums of squares
    a_diag_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !result.cov_xx[COV_W-1] && !result.cov_yy[COV_W-1] &&
            !result.cov_zz[COV_W-1])
        else $error("negative variance");

endmodule

bind gaussian_covariance_from_quat_scale_core gcqs_checker u_gcqs_checker (.*);
`default_nettype wire
